// ===== rtl/irt_pkg.sv =====
`default_nettype none

package irt_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int VALUE_W    = 32;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

  // register index, taken from the word address
  localparam logic REG_RADIX = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_SIGN,
    S_READ,
    S_SHOW
  } state_t;

  function automatic logic [RADIX_W-1:0] eff_base(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end else begin
      b = r;
    end
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > RADIX_W'(9)) begin
      c = CHAR_LOWER_A + CHAR_W'(d) - CHAR_W'(10);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_radix_text_core.sv =====
`default_nettype none

// Channel   Direction  Ports                                   Moves
// in_       input      in_valid, in_stall, in_value            one integer per request
// out_      output     out_valid, out_stall, out_character,    one character per request
//                      out_last
// config    APB slave  psel, penable, pwrite, paddr, pwdata,   radix register at byte 0
//                      prdata, pready
//
// Each integer is accepted, then every digit takes 32 shift-subtract steps on the shared restoring divider
// plus a store step; then a minus sign is sent if needed, and each digit is read from the digit store
// read port and sent.
// in_stall is high from acceptance until the last character is loaded into the output register;
// the last character may still wait there while the next integer is taken.
// Reset is synchronous; the digit store is not cleared.

module integer_to_radix_text_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [irt_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [irt_pkg::CHAR_W-1:0]        out_character,
  output logic                              out_last,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [irt_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [irt_pkg::DATA_W-1:0]   pwdata,
  output logic [irt_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  irt_pkg::state_t state_r, state_nxt;

  logic [irt_pkg::RADIX_W-1:0]   radix_r;
  logic [irt_pkg::RADIX_W-1:0]   base_r, base_nxt;
  logic                          neg_r, neg_nxt;
  logic [irt_pkg::VALUE_W-1:0]   quo_r, quo_nxt;
  logic [irt_pkg::RADIX_W-1:0]   rem_r, rem_nxt;
  logic [irt_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [irt_pkg::CNT_W-1:0]     n_r, n_nxt;
  logic [irt_pkg::CNT_W-1:0]     k_r, k_nxt;
  logic [irt_pkg::RADIX_W-1:0]   rd_data_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [irt_pkg::CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [irt_pkg::RADIX_W-1:0]   digit_store [irt_pkg::MAX_DIGITS];

  logic                          in_acc;
  logic                          out_free;
  logic                          cfg_wr;
  logic [irt_pkg::RADIX_W-1:0]   acc_base;
  logic                          acc_neg;
  logic [irt_pkg::RADIX_W:0]     rem_sh;
  logic                          ge;
  logic [irt_pkg::CNT_W-1:0]     cap;
  logic                          store_en;
  logic [irt_pkg::IDX_W-1:0]     rd_idx;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == irt_pkg::REG_RADIX) ?
                    irt_pkg::DATA_W'(radix_r) : '0;

  assign acc_base = irt_pkg::eff_base(radix_r);
  assign acc_neg  = (acc_base == irt_pkg::RADIX_DEC) && in_value[irt_pkg::VALUE_W-1];

  // one restoring divide step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_r, quo_r[irt_pkg::VALUE_W-1]};
  assign ge     = rem_sh >= {1'b0, base_r};

  assign cap      = irt_pkg::CNT_W'(irt_pkg::MAX_DIGITS) - irt_pkg::CNT_W'(neg_r);
  assign store_en = (state_r == irt_pkg::S_STORE) && (n_r < cap);
  assign rd_idx   = irt_pkg::IDX_W'(k_r - irt_pkg::CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      irt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = irt_pkg::S_DIV;
      end
      irt_pkg::S_DIV: begin
        if (bit_cnt_r == irt_pkg::BIT_CNT_W'(irt_pkg::VALUE_W - 1))
          state_nxt = irt_pkg::S_STORE;
      end
      irt_pkg::S_STORE: begin
        if (quo_r != '0) begin
          state_nxt = irt_pkg::S_DIV;
        end else if (neg_r) begin
          state_nxt = irt_pkg::S_SIGN;
        end else begin
          state_nxt = irt_pkg::S_READ;
        end
      end
      irt_pkg::S_SIGN: begin
        if (out_free) state_nxt = irt_pkg::S_READ;
      end
      irt_pkg::S_READ: begin
        state_nxt = irt_pkg::S_SHOW;
      end
      irt_pkg::S_SHOW: begin
        if (out_free) begin
          state_nxt = (k_r == irt_pkg::CNT_W'(1)) ? irt_pkg::S_IDLE : irt_pkg::S_READ;
        end
      end
      default: state_nxt = irt_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_stall      = (state_r != irt_pkg::S_IDLE);
    base_nxt      = base_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      irt_pkg::S_IDLE: begin
        if (in_acc) begin
          base_nxt    = acc_base;
          neg_nxt     = acc_neg;
          quo_nxt     = acc_neg ? (irt_pkg::VALUE_W'(0) - in_value) : in_value;
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          n_nxt       = '0;
        end
      end
      irt_pkg::S_DIV: begin
        quo_nxt     = {quo_r[irt_pkg::VALUE_W-2:0], ge};
        rem_nxt     = ge ? irt_pkg::RADIX_W'(rem_sh - {1'b0, base_r})
                         : irt_pkg::RADIX_W'(rem_sh);
        bit_cnt_nxt = bit_cnt_r + irt_pkg::BIT_CNT_W'(1);
      end
      irt_pkg::S_STORE: begin
        // drop the most significant digits once the store is full
        if (n_r < cap) n_nxt = n_r + irt_pkg::CNT_W'(1);
        k_nxt       = (n_r < cap) ? n_r + irt_pkg::CNT_W'(1) : n_r;
        rem_nxt     = '0;
        bit_cnt_nxt = '0;
      end
      irt_pkg::S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = irt_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
        end
      end
      irt_pkg::S_READ: begin
      end
      irt_pkg::S_SHOW: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = irt_pkg::digit_char(rd_data_r);
          out_last_nxt  = (k_r == irt_pkg::CNT_W'(1));
          k_nxt         = k_r - irt_pkg::CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= irt_pkg::S_IDLE;
      radix_r     <= irt_pkg::RADIX_RESET;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      if (cfg_wr && (paddr[2] == irt_pkg::REG_RADIX))
        radix_r <= pwdata[irt_pkg::RADIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    k_r        <= k_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // digit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_en) digit_store[n_r[irt_pkg::IDX_W-1:0]] <= rem_r;
    if (state_r == irt_pkg::S_READ) rd_data_r <= digit_store[rd_idx];
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == irt_pkg::S_DIV || state_r == irt_pkg::S_STORE) |-> (rem_r < base_r))
    else $error("remainder reached the base");

  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != irt_pkg::S_IDLE) |->
      (base_r >= irt_pkg::RADIX_MIN && base_r <= irt_pkg::RADIX_MAX))
    else $error("working base out of range");

  a_digit_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == irt_pkg::S_READ || state_r == irt_pkg::S_SHOW) |->
      (k_r != '0 && k_r <= n_r))
    else $error("digit pointer outside stored digits");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == irt_pkg::S_SHOW && out_free && k_r == irt_pkg::CNT_W'(1)) |=>
      (out_valid_r && out_last_r && state_r == irt_pkg::S_IDLE))
    else $error("final character not flagged");

endmodule

`default_nettype wire
